FILE: sv/sfm_pkg.sv
// Shared types, constants and codes of the scope frame measurement block.
package sfm_pkg;

  // Samples per capture frame.
  localparam int FRAME_LEN = 4096;

  localparam int IDX_W = 12;

  localparam logic [IDX_W-1:0] IDX_FIRST       = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_LAST        = IDX_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] IDX_TRACK_FIRST = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_TRACK_LAST  = IDX_W'(FRAME_LEN - 3);

  localparam logic [19:0] SUM_SEED    = 20'd2048;
  localparam logic [28:0] SQUARE_SEED = 29'd2048;
  localparam logic [7:0]  THRESH_OFFSET = 8'd4;
  localparam logic [7:0]  THRESH_GAP    = 8'd8;

  localparam logic [1:0] CH_A = 2'd0;
  localparam logic [1:0] CH_B = 2'd1;
  localparam logic [1:0] CH_C = 2'd2;
  localparam logic [1:0] CH_D = 2'd3;

  typedef enum logic [0:0] {
    REG_A_REFERENCE = 1'b0,
    REG_B_REFERENCE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_LOW  = 3'b001,
    MODE_HIGH = 3'b010,
    MODE_WAIT = 3'b100
  } track_mode_t;

  typedef struct packed {
    logic [7:0] level_a;
    logic [7:0] level_b;
    logic       logic_c;
    logic       logic_d;
  } sample_t;

  typedef struct packed {
    logic [1:0]  channel;
    logic [12:0] rising_count;
    logic [11:0] period_span;
    logic [11:0] high_width_sum;
    logic [19:0] level_sum;
    logic [27:0] square_sum;
    logic [7:0]  peak_max;
    logic [7:0]  peak_min;
    logic        last;
  } result_t;

  // Per-word control shared by all lanes.
  typedef struct packed {
    logic             accept;
    logic             first;
    logic             last;
    logic             track;
    logic [IDX_W-1:0] idx;
  } frame_ctrl_t;

  typedef struct packed {
    logic [19:0] level_sum;
    logic [27:0] square_sum;
    logic [7:0]  peak_max;
    logic [7:0]  peak_min;
  } analog_stats_t;

  typedef struct packed {
    logic [12:0] rising_count;
    logic [11:0] period_span;
    logic [11:0] high_width_sum;
  } track_stats_t;

endpackage

FILE: sv/scope_frame_measurement.sv
// Top level of the scope frame measurement block: lanes, frame counter and result merge.
//
//   channel   direction  handshake           word
//   sample    in         valid / stall       one capture sample (A, B, C, D)
//   result    out        valid / stall       one channel's frame result
//   cfg       in         valid / ready       register index and 8-bit data
//
// One sample word is taken every cycle unless the input stalls; all four lanes and
// both analog accumulators update in the cycle the word is accepted.
// The last word of a frame loads four results into the merge stage, which
// sends them as four words, A first and D last, one per cycle when unstalled.
// Sample input stalls only when a frame ends while results of the previous
// frame still wait in the merge stage. Reset is synchronous and active high.
module scope_frame_measurement (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  sfm_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_stall,
  output sfm_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  logic [sfm_pkg::IDX_W-1:0] sample_index;
  logic [sfm_pkg::IDX_W-1:0] sample_index_next;
  logic [7:0] a_reference;
  logic [7:0] b_reference;
  logic accept;
  logic frame_end;
  logic busy;

  sfm_pkg::frame_ctrl_t          ctrl;
  sfm_pkg::analog_stats_t        stats_a;
  sfm_pkg::analog_stats_t        stats_b;
  sfm_pkg::track_stats_t [3:0]   tracks;
  logic high_a, low_a, high_b, low_b;

  // Configuration registers are always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reference <= '0;
      b_reference <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfm_pkg::REG_A_REFERENCE: a_reference <= cfg_data;
        sfm_pkg::REG_B_REFERENCE: b_reference <= cfg_data;
        default: ;
      endcase
    end
  end

  // The frame end word cannot enter while the merge stage still holds results.
  assign frame_end    = sample_index == sfm_pkg::IDX_LAST;
  assign sample_stall = frame_end && busy;
  assign accept       = sample_valid && !sample_stall;

  assign sample_index_next = frame_end ? sfm_pkg::IDX_FIRST
                                       : sample_index + sfm_pkg::IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= sfm_pkg::IDX_FIRST;
    end else if (accept) begin
      sample_index <= sample_index_next;
    end
  end

  assign ctrl.accept = accept;
  assign ctrl.first  = sample_index == sfm_pkg::IDX_FIRST;
  assign ctrl.last   = frame_end;
  assign ctrl.track  = sample_index inside {[sfm_pkg::IDX_TRACK_FIRST:sfm_pkg::IDX_TRACK_LAST]};
  assign ctrl.idx    = sample_index;

  sfm_analog_lane u_lane_a (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .level     (sample.level_a),
    .reference (a_reference),
    .is_high   (high_a),
    .is_low    (low_a),
    .stats     (stats_a)
  );

  sfm_analog_lane u_lane_b (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .level     (sample.level_b),
    .reference (b_reference),
    .is_high   (high_b),
    .is_low    (low_b),
    .stats     (stats_b)
  );

  sfm_pulse_tracker u_track_a (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .is_high (high_a),
    .is_low  (low_a),
    .stats   (tracks[0])
  );

  sfm_pulse_tracker u_track_b (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .is_high (high_b),
    .is_low  (low_b),
    .stats   (tracks[1])
  );

  // Digital channels use the bit itself, without hysteresis.
  sfm_pulse_tracker u_track_c (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .is_high (sample.logic_c),
    .is_low  (!sample.logic_c),
    .stats   (tracks[2])
  );

  sfm_pulse_tracker u_track_d (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .is_high (sample.logic_d),
    .is_low  (!sample.logic_d),
    .stats   (tracks[3])
  );

  sfm_result_queue u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && frame_end),
    .stats_a      (stats_a),
    .stats_b      (stats_b),
    .tracks       (tracks),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Input is held back only while the merge stage has results to send.
  assert property (@(posedge clk) disable iff (rst) sample_stall |-> result_valid)
    else $error("sample input stalled with no result pending");

  // A frame end word brings the channel A result up in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (result_valid && result.channel == sfm_pkg::CH_A))
    else $error("frame end did not present the channel A result");

  // The frame counter restarts after the last word of a frame.
  assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (sample_index == sfm_pkg::IDX_FIRST))
    else $error("sample index did not restart after frame end");

  // Only the channel D result closes a frame's group of results.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (result.channel == sfm_pkg::CH_D))
    else $error("last flag set on a result other than channel D");

endmodule

FILE: sv/sfm_analog_lane.sv
// Analog channel lane: sum, squared deviation, extremes and hysteresis thresholds.
module sfm_analog_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  sfm_pkg::frame_ctrl_t  ctrl,
  input  logic [7:0]            level,
  input  logic [7:0]            reference,
  output logic                  is_high,
  output logic                  is_low,
  output sfm_pkg::analog_stats_t stats
);

  logic [19:0] sum_acc;
  logic [28:0] square_acc;
  logic [7:0]  running_max;
  logic [7:0]  running_min;
  logic [7:0]  thresh_high;
  logic [7:0]  thresh_low;

  logic [19:0]       sum_base;
  logic [28:0]       square_base;
  logic [7:0]        max_base;
  logic [7:0]        min_base;
  logic signed [8:0] dev;
  logic signed [17:0] dev_sq;
  logic [19:0]       sum_next;
  logic [28:0]       square_acc_next;
  logic [7:0]        running_max_next;
  logic [7:0]        running_min_next;
  logic [8:0]        mid_sum;
  logic [7:0]        thresh_high_next;

  // The first word of a frame restarts every accumulator before it adds in.
  assign sum_base    = ctrl.first ? sfm_pkg::SUM_SEED : sum_acc;
  assign square_base = ctrl.first ? sfm_pkg::SQUARE_SEED : square_acc;
  assign max_base    = ctrl.first ? reference : running_max;
  assign min_base    = ctrl.first ? reference : running_min;

  assign dev    = $signed({1'b0, level}) - $signed({1'b0, reference});
  assign dev_sq = dev * dev;

  assign sum_next         = sum_base + 20'(level);
  assign square_acc_next  = square_base + 29'(dev_sq[16:0]);
  assign running_max_next = (level > max_base) ? level : max_base;
  assign running_min_next = (level < min_base) ? level : min_base;

  assign mid_sum          = 9'({1'b0, running_max_next}) + 9'({1'b0, running_min_next});
  assign thresh_high_next = sfm_pkg::THRESH_OFFSET + mid_sum[8:1];

  assign is_high = level > thresh_high;
  assign is_low  = level < thresh_low;

  assign stats.level_sum  = sum_next;
  assign stats.square_sum = square_acc_next[27:0];
  assign stats.peak_max   = running_max_next;
  assign stats.peak_min   = running_min_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc     <= sfm_pkg::SUM_SEED;
      square_acc  <= sfm_pkg::SQUARE_SEED;
      running_max <= '0;
      running_min <= '0;
      thresh_high <= '0;
      thresh_low  <= '0;
    end else if (ctrl.accept) begin
      sum_acc     <= sum_next;
      square_acc  <= square_acc_next;
      running_max <= running_max_next;
      running_min <= running_min_next;
      if (ctrl.last) begin
        thresh_high <= thresh_high_next;
        thresh_low  <= thresh_high_next - sfm_pkg::THRESH_GAP;
      end
    end
  end

endmodule

FILE: sv/sfm_pulse_tracker.sv
// Pulse tracker lane: rising edges, first-to-last edge span and high widths.
module sfm_pulse_tracker (
  input  logic                 clk,
  input  logic                 rst,
  input  sfm_pkg::frame_ctrl_t ctrl,
  input  logic                 is_high,
  input  logic                 is_low,
  output sfm_pkg::track_stats_t stats
);

  sfm_pkg::track_mode_t mode, mode_next;
  logic [11:0] edge_start, edge_start_next;
  logic [11:0] first_edge, first_edge_next;
  logic [12:0] edge_count, edge_count_next;
  logic [11:0] width_total, width_total_next;

  always_comb begin
    mode_next        = mode;
    edge_start_next  = edge_start;
    first_edge_next  = first_edge;
    edge_count_next  = edge_count;
    width_total_next = width_total;
    if (ctrl.accept && ctrl.first) begin
      mode_next        = sfm_pkg::MODE_WAIT;
      edge_start_next  = '0;
      first_edge_next  = '0;
      edge_count_next  = '0;
      width_total_next = '0;
    end else if (ctrl.accept && ctrl.track) begin
      // While waiting for the first high, both marks follow the sample index.
      if (mode == sfm_pkg::MODE_WAIT) begin
        edge_start_next  = ctrl.idx;
        first_edge_next  = ctrl.idx;
        width_total_next = '0;
      end
      if (is_high) begin
        if (mode == sfm_pkg::MODE_LOW) begin
          edge_start_next = ctrl.idx;
          edge_count_next = edge_count + 13'd1;
        end
        mode_next = sfm_pkg::MODE_HIGH;
      end else if (is_low && mode == sfm_pkg::MODE_HIGH) begin
        mode_next        = sfm_pkg::MODE_LOW;
        width_total_next = width_total + (ctrl.idx - edge_start);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sfm_pkg::MODE_WAIT;
      edge_start  <= '0;
      first_edge  <= '0;
      edge_count  <= '0;
      width_total <= '0;
    end else begin
      mode        <= mode_next;
      edge_start  <= edge_start_next;
      first_edge  <= first_edge_next;
      edge_count  <= edge_count_next;
      width_total <= width_total_next;
    end
  end

  assign stats.rising_count   = edge_count;
  assign stats.period_span    = edge_start - first_edge;
  assign stats.high_width_sum = width_total;

endmodule

FILE: sv/sfm_result_queue.sv
// Merging stage: captures the four channel results of a frame and sends them in order.
module sfm_result_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  sfm_pkg::analog_stats_t      stats_a,
  input  sfm_pkg::analog_stats_t      stats_b,
  input  sfm_pkg::track_stats_t [3:0] tracks,
  output logic                        busy,
  output logic                        result_valid,
  input  logic                        result_stall,
  output sfm_pkg::result_t            result
);

  sfm_pkg::result_t slot [4];
  logic [1:0] ptr;

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= '{channel: sfm_pkg::CH_A, rising_count: tracks[0].rising_count,
                   period_span: tracks[0].period_span,
                   high_width_sum: tracks[0].high_width_sum,
                   level_sum: stats_a.level_sum, square_sum: stats_a.square_sum,
                   peak_max: stats_a.peak_max, peak_min: stats_a.peak_min, last: 1'b0};
      slot[1] <= '{channel: sfm_pkg::CH_B, rising_count: tracks[1].rising_count,
                   period_span: tracks[1].period_span,
                   high_width_sum: tracks[1].high_width_sum,
                   level_sum: stats_b.level_sum, square_sum: stats_b.square_sum,
                   peak_max: stats_b.peak_max, peak_min: stats_b.peak_min, last: 1'b0};
      slot[2] <= '{channel: sfm_pkg::CH_C, rising_count: tracks[2].rising_count,
                   period_span: tracks[2].period_span,
                   high_width_sum: tracks[2].high_width_sum,
                   level_sum: '0, square_sum: '0, peak_max: '0, peak_min: '0, last: 1'b0};
      slot[3] <= '{channel: sfm_pkg::CH_D, rising_count: tracks[3].rising_count,
                   period_span: tracks[3].period_span,
                   high_width_sum: tracks[3].high_width_sum,
                   level_sum: '0, square_sum: '0, peak_max: '0, peak_min: '0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      ptr  <= '0;
    end else if (busy && !result_stall) begin
      if (ptr == 2'd3) begin
        busy <= 1'b0;
      end
      ptr <= ptr + 2'd1;
    end
  end

  assign result_valid = busy;
  assign result       = slot[ptr];

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for scope_frame_measurement: capture frames checked by a predictor.
module testbench;

  // Cycles allowed after the last expected result before the block counts as idle.
  localparam int SETTLE_CYCLES = 8;
  // Cycles a drain may take; covers the long result hold-off with room to spare.
  localparam int DRAIN_LIMIT   = 20000;
  // Several times the slowest correct run, in which every word waits behind the
  // longest sender gap; the limit is in time units.
  localparam int RUN_LIMIT     = 12_000_000;
  // Long enough that the results of one frame are still waiting when the next
  // frame ends, which must stall the sample input.
  localparam int HOLD_CYCLES   = 2 * sfm_pkg::FRAME_LEN + 400;
  localparam int REPORT_LIMIT  = 10;

  // Segment kinds of the generated analog waveform.
  localparam logic [1:0] SEG_LOW  = 2'd0;
  localparam logic [1:0] SEG_BAND = 2'd1;
  localparam logic [1:0] SEG_HIGH = 2'd2;

  typedef enum logic [1:0] {
    STYLE_FLAT,
    STYLE_NOISE,
    STYLE_PULSE
  } frame_style_t;

  logic             clk;
  logic             rst;
  logic             sample_valid;
  logic             sample_stall;
  sfm_pkg::sample_t sample;
  logic             result_valid;
  logic             result_stall;
  sfm_pkg::result_t result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [0:0]       cfg_index;
  logic [7:0]       cfg_data;

  // Predictor state: position in the frame, one pulse tracker per channel and
  // the statistics of the two analog channels.
  logic [sfm_pkg::IDX_W-1:0] frame_pos;
  sfm_pkg::track_mode_t      tracker[4];
  logic [11:0]               rise_at[4];
  logic [11:0]               first_high_at[4];
  logic [11:0]               high_total[4];
  logic [12:0]               rises[4];
  logic [19:0]               level_total[2];
  logic [28:0]               deviation_total[2];
  logic [7:0]                peak_hi[2];
  logic [7:0]                peak_lo[2];
  logic [7:0]                thresh_hi[2];
  logic [7:0]                thresh_lo[2];
  logic [7:0]                zero_level[2];

  // Channel results that the words accepted so far must still produce, oldest first.
  sfm_pkg::result_t pending_results[$];

  int mismatches      = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int hold_left       = 0;
  bit sender_gaps     = 1'b0;
  bit receiver_gaps   = 1'b0;

  scope_frame_measurement i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endfunction

  // Advances the predicted block by one accepted capture word and queues the
  // four channel results when the word closes a frame.
  task automatic measure_sample(input sfm_pkg::sample_t s);
    logic [7:0]       lv[2];
    logic [7:0]       mid;
    logic             hit_hi;
    logic             hit_lo;
    int               dev;
    int               c;
    sfm_pkg::result_t r;
    lv[0] = s.level_a;
    lv[1] = s.level_b;
    // The first word of a frame reseeds the trackers and statistics; peaks start at the reference.
    if (frame_pos == sfm_pkg::IDX_FIRST) begin
      for (c = 0; c < 4; c++) begin
        tracker[c]       = sfm_pkg::MODE_WAIT;
        rise_at[c]       = '0;
        first_high_at[c] = '0;
        rises[c]         = '0;
        high_total[c]    = '0;
      end
      for (c = 0; c < 2; c++) begin
        level_total[c]     = sfm_pkg::SUM_SEED;
        deviation_total[c] = sfm_pkg::SQUARE_SEED;
        peak_hi[c]         = zero_level[c];
        peak_lo[c]         = zero_level[c];
      end
    end
    for (c = 0; c < 2; c++) begin
      dev = int'(lv[c]) - int'(zero_level[c]);
      level_total[c]     = level_total[c] + 20'(lv[c]);
      deviation_total[c] = deviation_total[c] + 29'(dev * dev);
      if (lv[c] > peak_hi[c]) peak_hi[c] = lv[c];
      if (lv[c] < peak_lo[c]) peak_lo[c] = lv[c];
    end
    // Pulse tracking runs only inside the window; the two words at each end of
    // the frame never move a tracker.
    if (frame_pos >= sfm_pkg::IDX_TRACK_FIRST && frame_pos <= sfm_pkg::IDX_TRACK_LAST) begin
      for (c = 0; c < 4; c++) begin
        if (c < 2) begin
          // Between the two thresholds neither flag is set, so the tracker holds.
          hit_hi = lv[c] > thresh_hi[c];
          hit_lo = lv[c] < thresh_lo[c];
        end else begin
          hit_hi = (c == 2) ? s.logic_c : s.logic_d;
          hit_lo = !hit_hi;
        end
        // A tracker still waiting for its first high drags both marks along,
        // which leaves a zero span when no high ever comes.
        if (tracker[c] == sfm_pkg::MODE_WAIT) begin
          rise_at[c]       = frame_pos;
          first_high_at[c] = frame_pos;
          high_total[c]    = '0;
        end
        if (hit_hi) begin
          if (tracker[c] == sfm_pkg::MODE_LOW) begin
            rise_at[c] = frame_pos;
            rises[c]   = rises[c] + 1'b1;
          end
          tracker[c] = sfm_pkg::MODE_HIGH;
        end else if (hit_lo && tracker[c] == sfm_pkg::MODE_HIGH) begin
          tracker[c]    = sfm_pkg::MODE_LOW;
          high_total[c] = high_total[c] + (frame_pos - rise_at[c]);
        end
      end
    end
    if (frame_pos == sfm_pkg::IDX_LAST) begin
      // New hysteresis thresholds for the next frame; both wrap in eight bits.
      for (c = 0; c < 2; c++) begin
        mid          = 8'((9'(peak_hi[c]) + 9'(peak_lo[c])) >> 1);
        thresh_hi[c] = mid + sfm_pkg::THRESH_OFFSET;
        thresh_lo[c] = thresh_hi[c] - sfm_pkg::THRESH_GAP;
      end
      for (c = 0; c < 4; c++) begin
        r                = '0;
        r.channel        = 2'(c);
        r.rising_count   = rises[c];
        r.period_span    = rise_at[c] - first_high_at[c];
        r.high_width_sum = high_total[c];
        if (r.channel <= sfm_pkg::CH_B) begin
          r.level_sum  = level_total[c];
          r.square_sum = deviation_total[c][27:0];
          r.peak_max   = peak_hi[c];
          r.peak_min   = peak_lo[c];
        end
        r.last = (r.channel == sfm_pkg::CH_D);
        pending_results.push_back(r);
      end
      frame_pos = sfm_pkg::IDX_FIRST;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // Offers one capture word, with an occasional gap before it, and holds it
  // steady until the block takes it.
  task automatic offer_sample(input sfm_pkg::sample_t s);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    measure_sample(s);
    samples_sent++;
  endtask

  task automatic write_reference(input sfm_pkg::cfg_reg_t which, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    zero_level[int'(which)] = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering words and waits until every expected result has arrived,
  // then waits out the settle time so that the block is idle for a register write.
  task automatic wait_drained();
    int waited;
    waited = 0;
    sample_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends count words. Pulse style builds runs of low, in-band and high levels
  // around the current thresholds, with digital channels toggling after random
  // run lengths and a rare glitch thrown in.
  task automatic send_samples(input frame_style_t style, input sfm_pkg::sample_t flat,
                              input int count, input int max_run);
    sfm_pkg::sample_t s;
    logic [7:0]       level[2];
    logic [1:0]       seg[4];
    int               run_left[4];
    int               lo;
    int               hi;
    int               n;
    int               c;
    for (c = 0; c < 4; c++) begin
      run_left[c] = 0;
      seg[c]      = 2'($urandom_range(0, 1));
    end
    for (n = 0; n < count; n++) begin
      case (style)
        STYLE_FLAT: begin
          s = flat;
        end
        STYLE_NOISE: begin
          s.level_a = 8'($urandom);
          s.level_b = 8'($urandom);
          s.logic_c = 1'($urandom);
          s.logic_d = 1'($urandom);
        end
        default: begin
          for (c = 0; c < 4; c++) begin
            if (run_left[c] == 0) begin
              run_left[c] = $urandom_range(1, max_run);
              if (c < 2) seg[c] = 2'($urandom_range(SEG_LOW, SEG_HIGH));
              else seg[c] = {1'b0, ~seg[c][0]};
            end
            run_left[c]--;
          end
          for (c = 0; c < 2; c++) begin
            lo = int'(thresh_lo[c]);
            hi = int'(thresh_hi[c]);
            case (seg[c])
              SEG_LOW: begin
                level[c] = (lo == 0) ? 8'd0 :
                           8'($urandom_range((lo > 12) ? lo - 12 : 0, lo - 1));
              end
              SEG_HIGH: begin
                level[c] = (hi == 255) ? 8'd255 :
                           8'($urandom_range(hi + 1, (hi < 243) ? hi + 12 : 255));
              end
              default: begin
                level[c] = (lo <= hi) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
              end
            endcase
            if ($urandom_range(0, 63) == 0) level[c] = 8'($urandom);
          end
          s.level_a = level[0];
          s.level_b = level[1];
          s.logic_c = seg[2][0];
          s.logic_d = seg[3][0];
        end
      endcase
      offer_sample(s);
    end
  endtask

  // Frame zero with the references and thresholds as reset leaves them. The
  // opening words swing every field between values near its extremes, with edges on the
  // two words before the tracking window; the closing words put edges on the
  // last tracked word and on the two words after it.
  task automatic test_directed_start();
    sfm_pkg::sample_t s;
    int               n;
    for (n = 0; n < 16; n++) begin
      s.level_a = n[0] ? 8'(n) : 8'(255 - n);
      s.level_b = n[0] ? 8'(255 - n) : 8'(n);
      s.logic_c = n[0];
      s.logic_d = n[1];
      offer_sample(s);
    end
    send_samples(STYLE_PULSE, '0, sfm_pkg::FRAME_LEN - 20, 6);
    for (n = 0; n < 4; n++) begin
      s.level_a = n[0] ? 8'hFF : 8'h00;
      s.level_b = n[0] ? 8'h00 : 8'hFF;
      s.logic_c = n[0];
      s.logic_d = !n[0];
      offer_sample(s);
    end
  endtask

  // Constant full-scale frames. The first, with every sample equal to its
  // reference, drives the next thresholds past the top and bottom of the byte.
  // The second gives the largest sums and squared deviations; one digital
  // channel never goes high, so its tracker waits all frame long.
  task automatic test_full_scale();
    sfm_pkg::sample_t flat;
    wait_drained();
    write_reference(sfm_pkg::REG_A_REFERENCE, 8'hFF);
    write_reference(sfm_pkg::REG_B_REFERENCE, 8'h00);
    flat.level_a = 8'hFF;
    flat.level_b = 8'h00;
    flat.logic_c = 1'b1;
    flat.logic_d = 1'b0;
    send_samples(STYLE_FLAT, flat, sfm_pkg::FRAME_LEN, 1);
    wait_drained();
    write_reference(sfm_pkg::REG_A_REFERENCE, 8'h00);
    write_reference(sfm_pkg::REG_B_REFERENCE, 8'hFF);
    flat.logic_c = 1'b0;
    flat.logic_d = 1'b1;
    send_samples(STYLE_FLAT, flat, sfm_pkg::FRAME_LEN, 1);
  endtask

  task automatic test_noise_and_fast_pulses();
    wait_drained();
    write_reference(sfm_pkg::REG_A_REFERENCE, 8'($urandom));
    write_reference(sfm_pkg::REG_B_REFERENCE, 8'($urandom));
    send_samples(STYLE_NOISE, '0, sfm_pkg::FRAME_LEN, 1);
    send_samples(STYLE_PULSE, '0, sfm_pkg::FRAME_LEN, 2);
  endtask

  // The receiver holds off across two frame ends while the sender keeps
  // offering words, so the block has to stall its sample input.
  task automatic test_result_backpressure();
    wait_drained();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    hold_left     = HOLD_CYCLES;
    send_samples(STYLE_PULSE, '0, 3 * sfm_pkg::FRAME_LEN, 24);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  task automatic test_reference_sweep();
    int k;
    for (k = 0; k < 2; k++) begin
      wait_drained();
      write_reference(sfm_pkg::REG_A_REFERENCE, 8'($urandom));
      write_reference(sfm_pkg::REG_B_REFERENCE, 8'($urandom));
      send_samples(STYLE_PULSE, '0, sfm_pkg::FRAME_LEN, (k == 0) ? 60 : 200);
    end
  endtask

  // Closing frames at full rate with no idling on either side.
  task automatic test_steady_stream();
    wait_drained();
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    write_reference(sfm_pkg::REG_A_REFERENCE, 8'h80);
    write_reference(sfm_pkg::REG_B_REFERENCE, 8'h7F);
    send_samples(STYLE_PULSE, '0, sfm_pkg::FRAME_LEN, 8);
    send_samples(STYLE_NOISE, '0, sfm_pkg::FRAME_LEN, 1);
  endtask

  // Result side: random stall bursts, or one long counted hold-off on request.
  initial begin : result_receiver
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Every accepted result word is compared field by field with the oldest
  // pending expectation.
  initial begin : result_check
    sfm_pkg::result_t want;
    string            diffs;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result word with nothing expected: %p", result));
        end else begin
          want  = pending_results.pop_front();
          diffs = "";
          if (result.channel !== want.channel) diffs = {diffs, " channel"};
          if (result.rising_count !== want.rising_count) diffs = {diffs, " rising_count"};
          if (result.period_span !== want.period_span) diffs = {diffs, " period_span"};
          if (result.high_width_sum !== want.high_width_sum) diffs = {diffs, " high_width_sum"};
          if (result.level_sum !== want.level_sum) diffs = {diffs, " level_sum"};
          if (result.square_sum !== want.square_sum) diffs = {diffs, " square_sum"};
          if (result.peak_max !== want.peak_max) diffs = {diffs, " peak_max"};
          if (result.peak_min !== want.peak_min) diffs = {diffs, " peak_min"};
          if (result.last !== want.last) diffs = {diffs, " last"};
          if (diffs != "") begin
            note_mismatch($sformatf("result word %0d differs in%s: expected %p, got %p",
                                    results_checked, diffs, want, result));
          end
        end
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("Run stopped at %0t with %0d results still expected",
             $time, pending_results.size());
    $display("scope_frame_measurement: mismatch");
    $finish;
  end

  initial begin : stimulus
    int c;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= sfm_pkg::REG_A_REFERENCE;
    cfg_data     <= '0;
    // Predictor state after reset: both references and thresholds at zero.
    frame_pos = sfm_pkg::IDX_FIRST;
    for (c = 0; c < 2; c++) begin
      zero_level[c] = '0;
      thresh_hi[c]  = '0;
      thresh_lo[c]  = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;

    test_directed_start();
    test_full_scale();
    test_noise_and_fast_pulses();
    test_result_backpressure();
    test_reference_sweep();
    test_steady_stream();
    wait_drained();

    $display("Sent %0d capture words in %0d frames and checked %0d channel results.",
             samples_sent, samples_sent / sfm_pkg::FRAME_LEN, results_checked);
    $display("Frames: full scale, wrapped thresholds, noise, pulse trains, long result hold-off.");
    if (mismatches == 0) begin
      $display("scope_frame_measurement: match");
    end else begin
      $display("scope_frame_measurement: mismatch");
    end
    $finish;
  end

endmodule
